FILE: rtl/core/tec_pkg.sv
package tec_pkg;

    localparam int CW   = 16;
    localparam int DW   = CW + 1;
    localparam int SQW  = 2 * CW;
    localparam int DSW  = SQW + 1;
    localparam int XPW  = 2 * DW;
    localparam int XSW  = XPW + 1;
    localparam int SCALE = 10000;
    localparam int SCW  = 14;
    localparam int SDW  = DSW + SCW;
    localparam int NV   = 3;
    localparam int NP   = NV * NV;
    localparam int EW   = 2;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_pt;

    typedef t_pt [NV-1:0] t_tri;

    typedef struct packed {
        logic [NV-1:0][NV-1:0][DSW-1:0] vtx_dist;
        logic [NV-1:0][DSW-1:0]         len_a;
        logic [NV-1:0][DSW-1:0]         len_b;
        logic [NV-1:0][NV-1:0]          left_ab;
        logic [NV-1:0][NV-1:0]          left_ba;
    } t_geom;

    localparam logic [EW-1:0] PAIR_EA [NP] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
                                               2'd2, 2'd2, 2'd2};
    localparam logic [EW-1:0] PAIR_EB [NP] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
                                               2'd0, 2'd1, 2'd2};

endpackage

FILE: rtl/core/tec_geom.sv
module tec_geom (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tec_pkg::t_tri  i_tri_a,
    input  tec_pkg::t_tri  i_tri_b,
    output logic           o_valid,
    output tec_pkg::t_geom o_geom
);
    import tec_pkg::*;

    function automatic logic signed [DW-1:0] f_sub(input t_coord p, input t_coord q);
        f_sub = DW'(p) - DW'(q);
    endfunction

    logic r_vld_m;
    logic r_vld_s;

    wire [NV-1:0][NV-1:0][DSW-1:0] dist_w;
    wire [NV-1:0][DSW-1:0]         len_a_w;
    wire [NV-1:0][DSW-1:0]         len_b_w;
    wire [NV-1:0][NV-1:0]          left_ab_w;
    wire [NV-1:0][NV-1:0]          left_ba_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_m <= 1'b0;
            r_vld_s <= 1'b0;
        end else begin
            r_vld_m <= i_valid;
            r_vld_s <= r_vld_m;
        end
    end

    for (genvar gi = 0; gi < NV; gi++) begin : g_row
        localparam int NI = (gi + 1) % NV;

        // edge lengths
        logic signed [DW-1:0]  lax, lay, lbx, lby;
        logic signed [XPW-1:0] n_lax, n_lay, n_lbx, n_lby;
        logic [SQW-1:0]        r_lax, r_lay, r_lbx, r_lby;
        logic [DSW-1:0]        r_len_a, r_len_b;

        assign lax   = f_sub(i_tri_a[NI].x, i_tri_a[gi].x);
        assign lay   = f_sub(i_tri_a[NI].y, i_tri_a[gi].y);
        assign lbx   = f_sub(i_tri_b[NI].x, i_tri_b[gi].x);
        assign lby   = f_sub(i_tri_b[NI].y, i_tri_b[gi].y);
        assign n_lax = lax * lax;
        assign n_lay = lay * lay;
        assign n_lbx = lbx * lbx;
        assign n_lby = lby * lby;

        always_ff @(posedge i_clk) begin
            r_lax   <= n_lax[SQW-1:0];
            r_lay   <= n_lay[SQW-1:0];
            r_lbx   <= n_lbx[SQW-1:0];
            r_lby   <= n_lby[SQW-1:0];
            r_len_a <= {1'b0, r_lax} + {1'b0, r_lay};
            r_len_b <= {1'b0, r_lbx} + {1'b0, r_lby};
        end

        assign len_a_w[gi] = r_len_a;
        assign len_b_w[gi] = r_len_b;

        for (genvar gk = 0; gk < NV; gk++) begin : g_col
            // vertex distance A[gi] to B[gk]
            logic signed [DW-1:0]  dx, dy;
            logic signed [XPW-1:0] n_sx, n_sy;
            logic [SQW-1:0]        r_sx, r_sy;
            logic [DSW-1:0]        r_dist;

            // A edge gi against B vertex gk, B edge gi against A vertex gk
            logic signed [DW-1:0]  abx, aby, apx, apy;
            logic signed [DW-1:0]  bbx, bby, bpx, bpy;
            logic signed [XPW-1:0] n_ab1, n_ab2, n_ba1, n_ba2;
            logic signed [XPW-1:0] r_ab1, r_ab2, r_ba1, r_ba2;
            logic signed [XSW-1:0] ab_cr, ba_cr;
            logic                  r_left_ab, r_left_ba;

            assign dx   = f_sub(i_tri_b[gk].x, i_tri_a[gi].x);
            assign dy   = f_sub(i_tri_b[gk].y, i_tri_a[gi].y);
            assign n_sx = dx * dx;
            assign n_sy = dy * dy;

            assign abx   = f_sub(i_tri_a[NI].x, i_tri_a[gi].x);
            assign aby   = f_sub(i_tri_a[NI].y, i_tri_a[gi].y);
            assign apx   = f_sub(i_tri_b[gk].x, i_tri_a[gi].x);
            assign apy   = f_sub(i_tri_b[gk].y, i_tri_a[gi].y);
            assign n_ab1 = abx * apy;
            assign n_ab2 = aby * apx;

            assign bbx   = f_sub(i_tri_b[NI].x, i_tri_b[gi].x);
            assign bby   = f_sub(i_tri_b[NI].y, i_tri_b[gi].y);
            assign bpx   = f_sub(i_tri_a[gk].x, i_tri_b[gi].x);
            assign bpy   = f_sub(i_tri_a[gk].y, i_tri_b[gi].y);
            assign n_ba1 = bbx * bpy;
            assign n_ba2 = bby * bpx;

            assign ab_cr = XSW'(r_ab1) - XSW'(r_ab2);
            assign ba_cr = XSW'(r_ba1) - XSW'(r_ba2);

            always_ff @(posedge i_clk) begin
                r_sx      <= n_sx[SQW-1:0];
                r_sy      <= n_sy[SQW-1:0];
                r_ab1     <= n_ab1;
                r_ab2     <= n_ab2;
                r_ba1     <= n_ba1;
                r_ba2     <= n_ba2;
                r_dist    <= {1'b0, r_sx} + {1'b0, r_sy};
                r_left_ab <= !ab_cr[XSW-1] && (ab_cr != '0);
                r_left_ba <= !ba_cr[XSW-1] && (ba_cr != '0);
            end

            assign dist_w[gi][gk]    = r_dist;
            assign left_ab_w[gi][gk] = r_left_ab;
            assign left_ba_w[gi][gk] = r_left_ba;
        end
    end

    assign o_valid = r_vld_s;
    assign o_geom  = '{vtx_dist: dist_w, len_a: len_a_w, len_b: len_b_w,
                       left_ab: left_ab_w, left_ba: left_ba_w};

endmodule

FILE: rtl/core/tec_pair.sv
module tec_pair (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  tec_pkg::t_geom         i_geom,
    output logic                   o_valid,
    output logic [tec_pkg::NP-1:0] o_hit
);
    import tec_pkg::*;

    logic r_vld_1;
    logic r_vld_2;

    wire [NV-1:0][NV-1:0][SDW-1:0] sd_w;
    wire [NP-1:0]                  hit_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_1 <= 1'b0;
            r_vld_2 <= 1'b0;
        end else begin
            r_vld_1 <= i_valid;
            r_vld_2 <= r_vld_1;
        end
    end

    for (genvar gi = 0; gi < NV; gi++) begin : g_ea
        localparam int NI = (gi + 1) % NV;
        for (genvar gj = 0; gj < NV; gj++) begin : g_eb
            localparam int NJ = (gj + 1) % NV;

            logic [SDW-1:0] r_sd;
            logic [DSW-1:0] n_m;
            logic [DSW-1:0] r_m;
            logic           n_x;
            logic           r_x;
            logic           n_skip;
            logic           r_hit;

            assign n_m = (i_geom.len_a[gi] < i_geom.len_b[gj]) ?
                         i_geom.len_a[gi] : i_geom.len_b[gj];
            assign n_x = (i_geom.left_ab[gi][gj] ^ i_geom.left_ab[gi][NJ]) &
                         (i_geom.left_ba[gj][gi] ^ i_geom.left_ba[gj][NI]);

            // drop the pair when an endpoint sits too close to an endpoint of the other edge
            assign n_skip = (sd_w[gi][gj] < SDW'(r_m)) || (sd_w[gi][NJ] < SDW'(r_m)) ||
                            (sd_w[NI][gj] < SDW'(r_m)) || (sd_w[NI][NJ] < SDW'(r_m));

            always_ff @(posedge i_clk) begin
                r_sd  <= SDW'(i_geom.vtx_dist[gi][gj]) * SDW'(SCALE);
                r_m   <= n_m;
                r_x   <= n_x;
                r_hit <= r_x && !n_skip;
            end

            assign sd_w[gi][gj]     = r_sd;
            assign hit_w[gi*NV+gj]  = r_hit;
        end
    end

    assign o_valid = r_vld_2;
    assign o_hit   = hit_w;

endmodule

FILE: rtl/core/tec_select.sv
module tec_select (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [tec_pkg::NP-1:0] i_hit,
    output logic                   o_done,
    output logic                   o_overlap,
    output logic [tec_pkg::EW-1:0] o_edge_of_first,
    output logic [tec_pkg::EW-1:0] o_edge_of_second
);
    import tec_pkg::*;

    logic          r_done;
    logic          r_overlap;
    logic [EW-1:0] r_ea;
    logic [EW-1:0] r_eb;
    logic [EW-1:0] n_ea;
    logic [EW-1:0] n_eb;

    // lowest pair index wins
    always_comb begin
        n_ea = '0;
        n_eb = '0;
        for (int k = NP - 1; k >= 0; k--) begin
            if (i_hit[k]) begin
                n_ea = PAIR_EA[k];
                n_eb = PAIR_EB[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_overlap <= |i_hit;
        r_ea      <= n_ea;
        r_eb      <= n_eb;
    end

    assign o_done           = r_done;
    assign o_overlap        = r_overlap;
    assign o_edge_of_first  = r_ea;
    assign o_edge_of_second = r_eb;

endmodule

FILE: rtl/core/triangle_edge_crossing_test_core.sv
// Channel   | Handshake             | Payload
// ----------+-----------------------+---------------------------------------------
// command   | start high, busy low  | i_a_x0..i_a_y2, i_b_x0..i_b_y2 (s16 each)
// result    | o_done strobe, 1 cyc  | o_overlap, o_edge_of_first, o_edge_of_second
//
// One triangle pair is taken every cycle; busy stays low.
// o_done pulses after the transfer of its command, in command order, following the
// six register stages: input, products, sums, scaling, pair decision, result.
// Synchronous active-low reset clears all valid bits; data in flight is dropped.
// The receiver cannot stall, so the pipeline always advances.
module triangle_edge_crossing_test_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [tec_pkg::CW-1:0] i_a_x0,
    input  logic [tec_pkg::CW-1:0] i_a_y0,
    input  logic [tec_pkg::CW-1:0] i_a_x1,
    input  logic [tec_pkg::CW-1:0] i_a_y1,
    input  logic [tec_pkg::CW-1:0] i_a_x2,
    input  logic [tec_pkg::CW-1:0] i_a_y2,
    input  logic [tec_pkg::CW-1:0] i_b_x0,
    input  logic [tec_pkg::CW-1:0] i_b_y0,
    input  logic [tec_pkg::CW-1:0] i_b_x1,
    input  logic [tec_pkg::CW-1:0] i_b_y1,
    input  logic [tec_pkg::CW-1:0] i_b_x2,
    input  logic [tec_pkg::CW-1:0] i_b_y2,
    output logic                   o_done,
    output logic                   o_overlap,
    output logic [tec_pkg::EW-1:0] o_edge_of_first,
    output logic [tec_pkg::EW-1:0] o_edge_of_second
);
    import tec_pkg::*;

    logic          r_vld;
    t_tri          r_tri_a;
    t_tri          r_tri_b;
    logic          geom_vld;
    t_geom         geom;
    logic          pair_vld;
    logic [NP-1:0] pair_hit;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tri_a[0].x <= i_a_x0;
        r_tri_a[0].y <= i_a_y0;
        r_tri_a[1].x <= i_a_x1;
        r_tri_a[1].y <= i_a_y1;
        r_tri_a[2].x <= i_a_x2;
        r_tri_a[2].y <= i_a_y2;
        r_tri_b[0].x <= i_b_x0;
        r_tri_b[0].y <= i_b_y0;
        r_tri_b[1].x <= i_b_x1;
        r_tri_b[1].y <= i_b_y1;
        r_tri_b[2].x <= i_b_x2;
        r_tri_b[2].y <= i_b_y2;
    end

    tec_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld),
        .i_tri_a (r_tri_a),
        .i_tri_b (r_tri_b),
        .o_valid (geom_vld),
        .o_geom  (geom)
    );

    tec_pair u_pair (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (geom_vld),
        .i_geom  (geom),
        .o_valid (pair_vld),
        .o_hit   (pair_hit)
    );

    tec_select u_select (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (pair_vld),
        .i_hit            (pair_hit),
        .o_done           (o_done),
        .o_overlap        (o_overlap),
        .o_edge_of_first  (o_edge_of_first),
        .o_edge_of_second (o_edge_of_second)
    );

endmodule

FILE: rtl/core/tec_checker.sv
module tec_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic [tec_pkg::CW-1:0] i_a_x0,
    input logic [tec_pkg::CW-1:0] i_a_y0,
    input logic [tec_pkg::CW-1:0] i_a_x1,
    input logic [tec_pkg::CW-1:0] i_a_y1,
    input logic [tec_pkg::CW-1:0] i_a_x2,
    input logic [tec_pkg::CW-1:0] i_a_y2,
    input logic [tec_pkg::CW-1:0] i_b_x0,
    input logic [tec_pkg::CW-1:0] i_b_y0,
    input logic [tec_pkg::CW-1:0] i_b_x1,
    input logic [tec_pkg::CW-1:0] i_b_y1,
    input logic [tec_pkg::CW-1:0] i_b_x2,
    input logic [tec_pkg::CW-1:0] i_b_y2,
    input logic                   o_done,
    input logic                   o_overlap,
    input logic [tec_pkg::EW-1:0] o_edge_of_first,
    input logic [tec_pkg::EW-1:0] o_edge_of_second
);
    import tec_pkg::*;

    a_no_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_done)
        else $error("result missing after command transfer");

    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy && i_rst_n, 6))
        else $error("result without command transfer");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_overlap) |-> (o_edge_of_first == '0 && o_edge_of_second == '0))
        else $error("edge indices set without crossing");

    a_edge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_edge_of_first != 2'd3 && o_edge_of_second != 2'd3))
        else $error("edge index out of range");

endmodule

bind triangle_edge_crossing_test_core tec_checker u_tec_checker (.*);
